// ===== rtl/core/pdeth_pkg.sv =====
// ----------------------------------------------------------------------------
// pdeth_pkg
// types and constants shared by the per-domain event type histogram unit
// ----------------------------------------------------------------------------
package pdeth_pkg;

    localparam logic [14:0] HOST_DOMAIN_ID = 15'h7fff;
    localparam logic [31:0] COUNT_MAX      = 32'hffff_ffff;
    localparam logic [47:0] TOTAL_MAX      = 48'hffff_ffff_ffff;

    typedef enum logic [1:0] {
        STATUS_HIT   = 2'd0,
        STATUS_NEW   = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [14:0] domain_id;
        logic [31:0] event_type;
    } event_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  domain_slot;
        logic [3:0]  entry_slot;
        logic [31:0] type_count;
        logic [47:0] domain_total;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic    clr_wr;
        logic    accept;
        logic    dom_load;
        logic    step;
        logic    finish;
        status_t code;
        logic    out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic bad;
        logic hit;
        logic more;
        logic pending;
        logic full;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/pdeth_datapath.sv =====
// ----------------------------------------------------------------------------
// pdeth_datapath
// domain and entry memories, search counters, result and output registers
// ----------------------------------------------------------------------------
module pdeth_datapath
    import pdeth_pkg::*;
#(
    parameter int DOMAINS          = 64,
    parameter int TYPES_PER_DOMAIN = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  event_t   event_data,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result_data
);

    localparam int DW  = $clog2(DOMAINS);
    localparam int UW  = $clog2(TYPES_PER_DOMAIN + 1);
    localparam int DCNT = DOMAINS * TYPES_PER_DOMAIN;
    localparam int AW  = $clog2(DCNT);
    localparam int DMW = UW + 48;

    // memories
    logic [DMW-1:0] dom_mem [DOMAINS];
    logic [63:0]    ent_mem [DCNT];

    logic [DMW-1:0] dom_rdata_reg;
    logic [63:0]    ent_rdata_reg;

    // item registers
    logic [31:0]   key_reg;
    logic [DW-1:0] slot_reg;
    logic          bad_reg;
    logic [UW-1:0] used_reg;
    logic [47:0]   total_reg;
    logic [AW-1:0] base_reg;
    logic [UW-1:0] rd_idx_reg;
    logic [UW-1:0] cmp_idx_reg;
    logic          cmp_valid_reg;
    logic [DW-1:0] clr_idx_reg;
    result_t       res_reg;
    result_t       out_data_reg;
    logic          out_valid_reg;

    logic          host;
    logic          bad_next;
    logic [DW-1:0] slot_next;
    logic [47:0]   total_old;
    logic [AW-1:0] ent_raddr;
    logic [31:0]   count_new;

    logic           dom_we;
    logic [DW-1:0]  dom_waddr;
    logic [UW-1:0]  dom_wused;
    logic [DMW-1:0] dom_wdata;
    logic           ent_we;
    logic [UW-1:0]  ent_widx;
    logic [63:0]    ent_wdata;
    result_t        res_next;

    assign host      = (event_data.domain_id == HOST_DOMAIN_ID);
    assign bad_next  = !host && (event_data.domain_id >= 15'(DOMAINS - 1));
    assign slot_next = host ? DW'(DOMAINS - 1) : event_data.domain_id[DW-1:0];

    assign total_old = dom_rdata_reg[47:0];
    assign ent_raddr = base_reg + AW'(rd_idx_reg);
    assign count_new = (ent_rdata_reg[31:0] == COUNT_MAX) ? ent_rdata_reg[31:0]
                                                          : ent_rdata_reg[31:0] + 32'd1;

    always_comb
    begin
        dom_we    = 1'b0;
        dom_waddr = slot_reg;
        dom_wused = used_reg;
        ent_we    = 1'b0;
        ent_widx  = used_reg;
        ent_wdata = {key_reg, 32'd1};
        res_next  = '{status: STATUS_RANGE, domain_slot: 6'd0, entry_slot: 4'd0,
                      type_count: 32'd0, domain_total: 48'd0};
        if (cmd.clr_wr)
        begin
            dom_we    = 1'b1;
            dom_waddr = clr_idx_reg;
            dom_wused = '0;
        end
        else if (cmd.finish)
        begin
            case (cmd.code)
                STATUS_HIT:
                begin
                    dom_we    = 1'b1;
                    ent_we    = 1'b1;
                    ent_widx  = cmp_idx_reg;
                    ent_wdata = {key_reg, count_new};
                    res_next  = '{status: STATUS_HIT, domain_slot: 6'(slot_reg),
                                  entry_slot: 4'(cmp_idx_reg), type_count: count_new,
                                  domain_total: total_reg};
                end
                STATUS_NEW:
                begin
                    dom_we    = 1'b1;
                    dom_wused = used_reg + UW'(1);
                    ent_we    = 1'b1;
                    res_next  = '{status: STATUS_NEW, domain_slot: 6'(slot_reg),
                                  entry_slot: 4'(used_reg), type_count: 32'd1,
                                  domain_total: total_reg};
                end
                STATUS_FULL:
                begin
                    dom_we   = 1'b1;
                    res_next = '{status: STATUS_FULL, domain_slot: 6'(slot_reg),
                                 entry_slot: 4'd0, type_count: 32'd0,
                                 domain_total: total_reg};
                end
                default:
                begin
                    dom_we = 1'b0;
                end
            endcase
        end
    end

    // cleared domains hold a zero total along with a zero fill count
    assign dom_wdata = cmd.clr_wr ? '0 : {dom_wused, total_reg};

    always_ff @(posedge clk)
    begin
        if (dom_we)
        begin
            dom_mem[dom_waddr] <= dom_wdata;
        end
        dom_rdata_reg <= dom_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[base_reg + AW'(ent_widx)] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[ent_raddr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg  <= event_data.event_type;
            slot_reg <= slot_next;
            bad_reg  <= bad_next;
        end
        if (cmd.dom_load)
        begin
            used_reg   <= dom_rdata_reg[DMW-1:48];
            total_reg  <= (total_old == TOTAL_MAX) ? total_old : total_old + 48'd1;
            base_reg   <= AW'(slot_reg) * AW'(TYPES_PER_DOMAIN);
            rd_idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            rd_idx_reg <= rd_idx_reg + UW'(1);
        end
        if (cmd.step)
        begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.step;
            if (cmd.clr_wr)
            begin
                clr_idx_reg <= clr_idx_reg + DW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clr_last = (clr_idx_reg == DW'(DOMAINS - 1));
    assign stat.bad      = bad_reg;
    assign stat.hit      = cmp_valid_reg && (ent_rdata_reg[63:32] == key_reg);
    assign stat.more     = (rd_idx_reg < used_reg);
    assign stat.pending  = cmp_valid_reg;
    assign stat.full     = (used_reg == UW'(TYPES_PER_DOMAIN));
    assign stat.out_free = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    a_ent_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ent_we |-> (ent_widx < UW'(TYPES_PER_DOMAIN)))
        else $error("entry write beyond the domain table");

    a_cmp_below_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (cmp_idx_reg < used_reg))
        else $error("compared entry not in use");

    a_no_write_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && bad_reg) |-> (!dom_we && !ent_we))
        else $error("state written for a refused domain");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !result_stall))
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/pdeth_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdeth_ctrl
// sequencer: clearing pass, lookup, search walk, finish and result hand-off
// ----------------------------------------------------------------------------
module pdeth_ctrl
    import pdeth_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     event_valid,
    output logic     event_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DOM,
        S_DLOAD,
        S_SEARCH,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{clr_wr: 1'b0, accept: 1'b0, dom_load: 1'b0, step: 1'b0,
                       finish: 1'b0, code: STATUS_RANGE, out_load: 1'b0};
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (event_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DOM;
                end
            end
            S_DOM:
            begin
                // domain record read is in flight here
                if (stat.bad)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = STATUS_RANGE;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.dom_load = 1'b1;
                state_next   = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = STATUS_HIT;
                    state_next = S_OUT;
                end
                else if (stat.more)
                begin
                    cmd.step = 1'b1;
                end
                else if (!stat.pending)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = stat.full ? STATUS_FULL : STATUS_NEW;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign event_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/per_domain_event_type_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// per_domain_event_type_histogram_unit
// counts trace events per domain and per event type, with a domain total
// ----------------------------------------------------------------------------
// event channel: event_valid / event_stall / event_data carry one trace event
// (domain id, event type). result channel: result_valid / result_stall /
// result_data carry exactly one result per event, in order.
// after reset the unit sweeps the domain memory, one domain a cycle, and
// holds event_stall high for the whole sweep before taking the first event.
// one event at a time is processed. the walk over the domain's type entries
// reads one entry memory location per cycle, and the next event can be
// accepted in the cycle in which result_valid rises.
// a result waits in the output register while result_stall is high; the
// next event is still accepted and processed meanwhile, and its result is
// handed over once the output register is free.
// ----------------------------------------------------------------------------
module per_domain_event_type_histogram_unit
    import pdeth_pkg::*;
#(
    parameter int DOMAINS          = 64,
    parameter int TYPES_PER_DOMAIN = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    event_valid,
    output logic    event_stall,
    input  event_t  event_data,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pdeth_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    pdeth_datapath #(
        .DOMAINS          (DOMAINS),
        .TYPES_PER_DOMAIN (TYPES_PER_DOMAIN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_data   (event_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the per-domain event type histogram unit. a
// clocked driver feeds trace events from a queue with random gaps, a clocked
// monitor applies random result stalls, and every result is checked field by
// field against an in-bench copy of the histogram tables
// ----------------------------------------------------------------------------
module tb_top;
    import pdeth_pkg::*;

    localparam int DOMAIN_COUNT = 64;
    localparam int TYPE_SLOTS   = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        event_t ev;
        bit     drain_first;
    } pending_event_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    event_valid  = 1'b0;
    logic    event_stall;
    event_t  event_data   = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_data;

    // shadow copy of the histogram tables
    logic [31:0] shadow_keys   [DOMAIN_COUNT][TYPE_SLOTS];
    logic [31:0] shadow_counts [DOMAIN_COUNT][TYPE_SLOTS];
    int          shadow_used   [DOMAIN_COUNT];
    logic [47:0] shadow_totals [DOMAIN_COUNT];

    pending_event_t pending_events[$];
    result_t        expected_results[$];

    int events_accepted = 0;
    int results_done    = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int status_seen[4]  = '{0, 0, 0, 0};
    int src_gap         = 0;
    int src_burst       = 0;
    int sink_wait       = 0;
    int sink_burst      = 0;

    per_domain_event_type_histogram_unit #(
        .DOMAINS          (DOMAIN_COUNT),
        .TYPES_PER_DOMAIN (TYPE_SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_data   (event_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic result_t histogram_update(event_t ev);
        result_t     r;
        logic [5:0]  slot;
        int          used;
        bit          found;
        r     = '0;
        found = 1'b0;
        if (ev.domain_id == HOST_DOMAIN_ID)
        begin
            slot = 6'(DOMAIN_COUNT - 1);
        end
        else if (ev.domain_id >= 15'(DOMAIN_COUNT - 1))
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        else
        begin
            slot = ev.domain_id[5:0];
        end
        if (shadow_totals[slot] != TOTAL_MAX)
        begin
            shadow_totals[slot] = shadow_totals[slot] + 48'd1;
        end
        r.domain_slot  = slot;
        r.domain_total = shadow_totals[slot];
        used = shadow_used[slot];
        for (int i = 0; i < used; i++)
        begin
            if (!found && shadow_keys[slot][i] == ev.event_type)
            begin
                found = 1'b1;
                if (shadow_counts[slot][i] != COUNT_MAX)
                begin
                    shadow_counts[slot][i] = shadow_counts[slot][i] + 32'd1;
                end
                r.status     = STATUS_HIT;
                r.entry_slot = 4'(i);
                r.type_count = shadow_counts[slot][i];
            end
        end
        if (!found)
        begin
            if (used >= TYPE_SLOTS)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                shadow_keys[slot][used]   = ev.event_type;
                shadow_counts[slot][used] = 32'd1;
                shadow_used[slot]         = used + 1;
                r.status     = STATUS_NEW;
                r.entry_slot = 4'(used);
                r.type_count = 32'd1;
            end
        end
        return r;
    endfunction

    // mostly no gap or a short one, a few long ones, and occasional stretches with none
    function automatic int pick_gap(ref int burst_left);
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
    endtask

    task automatic add_event(logic [14:0] dom, logic [31:0] etype, bit drain);
        pending_event_t p;
        p.ev.domain_id  = dom;
        p.ev.event_type = etype;
        p.drain_first   = drain;
        pending_events.push_back(p);
    endtask

    // driver
    always @(posedge clk)
    begin
        bit accepted;
        if (rst_n)
        begin
            accepted = event_valid && !event_stall;
            if (accepted)
            begin
                expected_results.push_back(histogram_update(event_data));
                void'(pending_events.pop_front());
                events_accepted++;
                src_gap = pick_gap(src_burst);
            end
            if (!event_valid || accepted)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    event_valid <= 1'b0;
                end
                else if (pending_events.size() > 0 &&
                         !(pending_events[0].drain_first &&
                           events_accepted != results_done))
                begin
                    event_valid <= 1'b1;
                    event_data  <= pending_events[0].ev;
                end
                else
                begin
                    event_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result sink
    always @(posedge clk)
    begin
        result_t exp;
        int      g;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    note_error($sformatf("unexpected result status=%0d slot=%0d",
                                         result_data.status, result_data.domain_slot));
                end
                else
                begin
                    exp = expected_results.pop_front();
                    results_done <= results_done + 1;
                    status_seen[exp.status]++;
                    if (result_data.status !== exp.status ||
                        result_data.domain_slot !== exp.domain_slot ||
                        result_data.entry_slot !== exp.entry_slot ||
                        result_data.type_count !== exp.type_count ||
                        result_data.domain_total !== exp.domain_total)
                    begin
                        note_error($sformatf(
                            "exp st=%0d ds=%0d es=%0d cnt=%h tot=%h, got st=%0d ds=%0d es=%0d cnt=%h tot=%h",
                            exp.status, exp.domain_slot, exp.entry_slot,
                            exp.type_count, exp.domain_total,
                            result_data.status, result_data.domain_slot,
                            result_data.entry_slot, result_data.type_count,
                            result_data.domain_total));
                    end
                end
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                result_stall <= 1'b1;
            end
            else
            begin
                g = pick_gap(sink_burst);
                result_stall <= (g > 0);
                sink_wait = (g > 0) ? g - 1 : 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("** per_domain_event_type_histogram_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int          r;
        int          idx;
        logic [14:0] dom;
        logic [31:0] etype;
        logic [14:0] hot_domains[8];
        hot_domains = '{15'd0, 15'd1, 15'd2, 15'd3, 15'd5, 15'd62,
                        HOST_DOMAIN_ID, 15'd40};
        for (int d = 0; d < DOMAIN_COUNT; d++)
        begin
            shadow_used[d]   = 0;
            shadow_totals[d] = '0;
        end

        // directed: field extremes, host folding, refused ids, a full table
        add_event(15'd0, 32'h0000_0000, 1'b0);
        add_event(15'd0, 32'hffff_ffff, 1'b0);
        add_event(HOST_DOMAIN_ID, 32'hdead_beef, 1'b0);
        add_event(HOST_DOMAIN_ID, 32'hdead_beef, 1'b0);
        add_event(15'd62, 32'h0000_0001, 1'b0);
        add_event(15'd63, 32'h0000_0001, 1'b0);
        add_event(15'h7ffe, 32'hffff_ffff, 1'b0);
        add_event(15'h4000, 32'h0000_0000, 1'b0);
        for (int i = 0; i < TYPE_SLOTS; i++)
        begin
            add_event(15'd1, 32'h0000_1000 + 32'(i), 1'b0);
        end
        add_event(15'd1, 32'h0000_2000, 1'b0);
        add_event(15'd1, 32'h0000_100f, 1'b0);

        // random: hot domains with small type pools so tables fill and hit
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                idx   = $urandom_range(0, 7);
                dom   = hot_domains[idx];
                etype = 32'ha5a5_0000 ^ 32'($urandom_range(0, 23));
            end
            else if (r < 80)
            begin
                dom   = 15'($urandom_range(0, DOMAIN_COUNT - 2));
                etype = $urandom;
            end
            else if (r < 90)
            begin
                dom   = HOST_DOMAIN_ID;
                etype = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
            end
            else
            begin
                dom   = 15'($urandom_range(DOMAIN_COUNT - 1, 32766));
                etype = $urandom;
            end
            add_event(dom, etype, (n == 0) || (n == RANDOM_ITEMS / 2));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_events.size() != 0 || event_valid ||
               events_accepted != results_done);
        repeat (40) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            note_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("run covered %0d events: %0d hits, %0d new types, %0d full-table refusals,",
                 events_accepted, status_seen[STATUS_HIT], status_seen[STATUS_NEW],
                 status_seen[STATUS_FULL]);
        $display("%0d refused domain ids, under random gaps and stalls; %0d errors",
                 status_seen[STATUS_RANGE], error_count);
        if (error_count == 0)
        begin
            $display("** per_domain_event_type_histogram_unit: PASSED **");
        end
        else
        begin
            $display("** per_domain_event_type_histogram_unit: FAILED **");
        end
        $finish;
    end

endmodule
